// ===== rtl/mrcs_pkg.sv =====
// Package with the shared types and constants of the matrix row and column statistics block.
package mrcs_pkg;

  localparam int unsigned ElemW   = 16;
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned GroupW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SumW    = 28;
  localparam int unsigned SqW     = 43;
  localparam int unsigned NW      = 13;
  localparam int unsigned MeanW   = 24;
  localparam int unsigned DevW    = 24;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_AXIS_MODE    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_ROW    = 2'd0,
    AXIS_COLUMN = 2'd1,
    AXIS_WHOLE  = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    S_ACC,
    S_DRAIN,
    S_READ,
    S_MUL,
    S_DIFF,
    S_MEAN,
    S_VAR,
    S_ROOT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [ElemW-1:0] element_value;
  } elem_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [CountW-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [GroupW-1:0]       group_index;
    logic signed [SumW-1:0]  group_sum;
    logic signed [MeanW-1:0] group_mean_q8;
    logic signed [ElemW-1:0] group_maximum;
    logic signed [ElemW-1:0] group_minimum;
    logic [DevW-1:0]         group_stddev_q8;
    logic                    last_result;
  } result_t;

  typedef struct packed {
    logic signed [SumW-1:0]  sum;
    logic [SqW-1:0]          sq;
    logic signed [ElemW-1:0] maxv;
    logic signed [ElemW-1:0] minv;
  } entry_t;

endpackage

// ===== rtl/mrcs_if.sv =====
// Valid/ready channel interfaces for elements, results and configuration writes.
interface mrcs_elem_if;
  logic            valid;
  logic            ready;
  mrcs_pkg::elem_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrcs_res_if;
  logic              valid;
  logic              ready;
  mrcs_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrcs_cfg_if;
  logic           valid;
  logic           ready;
  mrcs_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/matrix_row_column_statistics.sv =====
// Top level of the matrix row, column and whole-matrix statistics block.
//
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------------
//  cfg_i    | in  | write of row_count, column_count or axis_mode by index
//  elem_i   | in  | one matrix element, row-major order
//  res_o    | out | statistics of one group, last_result on the final one
//
// While a run accumulates, one element is taken every cycle. Each element
// reads its group's entry from the statistics memory, and the updated entry
// is written in the next cycle; a one-entry forwarding register covers an
// element that hits the entry just written. After the last element the
// block stops taking elements and register writes, and each group then
// goes through one memory read, the product steps, two 72-step shift-subtract
// divisions on one shared divider (mean, then scaled variance) and a
// 24-step square root.
// A result waits in the output register as long as res_o is stalled.
// Reset clears the positions and control registers; the memory needs no clearing,
// because a group's first element overwrites its entry.
module matrix_row_column_statistics (
  input  logic  clk_i,
  input  logic  rst_ni,
  mrcs_cfg_if.sink   cfg_i,
  mrcs_elem_if.sink  elem_i,
  mrcs_res_if.source res_o
);
  import mrcs_pkg::*;

  localparam int unsigned DivW  = 72;
  localparam int unsigned DvsW  = 25;
  localparam int unsigned RadW  = 48;
  localparam int unsigned RootW = 24;
  localparam int unsigned RremW = 26;

  // Configuration registers.
  logic [CountW-1:0] row_count_q, column_count_q;
  logic [1:0]        axis_mode_q;

  // Run positions.
  logic [GroupW-1:0] row_pos_q, col_pos_q;

  state_e state_q, state_d;

  // Accumulation pipeline stage after the memory read.
  logic                    s1_valid_q, s1_first_q;
  logic [GroupW-1:0]       s1_addr_q;
  logic signed [ElemW-1:0] s1_val_q;

  // Forwarding of the entry written in the previous cycle.
  logic              fwd_valid_q;
  logic [GroupW-1:0] fwd_addr_q;
  entry_t            fwd_entry_q;

  // Statistics memory.
  entry_t            mem_q [MaxRows];
  entry_t            rd_q;
  logic [GroupW-1:0] rd_addr;
  logic              wr_en;
  entry_t            wr_entry;

  // Emission datapath.
  logic [GroupW-1:0]       k_q;
  logic signed [SumW-1:0]  e_sum_q;
  logic signed [ElemW-1:0] e_max_q, e_min_q;
  logic [2*NW+29:0]        prod_a_q, prod_b_q;
  logic [DvsW-1:0]         nn_q;
  logic [DivW-1:0]         div_quo_q;
  logic [DvsW-1:0]         div_rem_q;
  logic [6:0]              cnt_q;
  logic [MeanW-1:0]        mean_q;
  logic [RadW-1:0]         rad_q;
  logic [RootW-1:0]        root_q;
  logic [RremW-1:0]        srem_q;
  result_t                 res_q;
  logic                    res_valid_q;

  // Effective configuration.
  logic [CountW-1:0] rows, cols;
  axis_e             mode;
  logic [NW-1:0]     n_grp;
  logic [CountW-1:0] groups;
  logic [2*CountW-1:0] rc_prod;

  always_comb begin
    rows = (row_count_q == '0) ? CountW'(1) :
           (row_count_q > CountW'(MaxRows)) ? CountW'(MaxRows) : row_count_q;
    cols = (column_count_q == '0) ? CountW'(1) :
           (column_count_q > CountW'(MaxCols)) ? CountW'(MaxCols) : column_count_q;
    rc_prod = rows * cols;
    case (axis_mode_q)
      AXIS_ROW: mode = AXIS_ROW;
      AXIS_COLUMN: mode = AXIS_COLUMN;
      default: mode = AXIS_WHOLE;
    endcase
    case (mode)
      AXIS_ROW: begin
        n_grp  = NW'(cols);
        groups = rows;
      end
      AXIS_COLUMN: begin
        n_grp  = NW'(rows);
        groups = cols;
      end
      default: begin
        n_grp  = rc_prod[NW-1:0];
        groups = CountW'(1);
      end
    endcase
  end

  // Group and group-start flag of the element on the input.
  logic [GroupW-1:0] in_group;
  logic              in_first, in_last, in_acc, cfg_wr, col_wrap;

  always_comb begin
    case (mode)
      AXIS_ROW: begin
        in_group = row_pos_q;
        in_first = (col_pos_q == '0);
      end
      AXIS_COLUMN: begin
        in_group = col_pos_q;
        in_first = (row_pos_q == '0);
      end
      default: begin
        in_group = '0;
        in_first = (row_pos_q == '0) && (col_pos_q == '0);
      end
    endcase
    col_wrap = ({1'b0, col_pos_q} == cols - CountW'(1));
    in_last  = col_wrap && ({1'b0, row_pos_q} == rows - CountW'(1));
  end

  assign in_acc = elem_i.valid && elem_i.ready;
  assign cfg_wr = cfg_i.valid && cfg_i.ready;

  // Divider and square root step logic.
  logic [DvsW-1:0] divisor;
  logic [DvsW:0]   div_shift, div_diff;
  logic            div_ge;
  logic [RremW+1:0] sq_shift, sq_trial;
  logic            sq_ge;
  logic [RootW-1:0] root_d;
  logic [DivW-1:0]  div_quo_d;
  logic [DvsW-1:0]  div_rem_d;
  logic [RremW-1:0] srem_d;

  always_comb begin
    divisor   = (state_q == S_MEAN) ? DvsW'(n_grp) : nn_q;
    div_shift = {div_rem_q, div_quo_q[DivW-1]};
    div_ge    = (div_shift >= {1'b0, divisor});
    div_diff  = div_shift - {1'b0, divisor};
    div_rem_d = div_ge ? div_diff[DvsW-1:0] : div_shift[DvsW-1:0];
    div_quo_d = {div_quo_q[DivW-2:0], div_ge};
    sq_shift  = {srem_q, rad_q[RadW-1 -: 2]};
    sq_trial  = {2'b00, root_q, 2'b01};
    sq_ge     = (sq_shift >= sq_trial);
    srem_d    = sq_ge ? RremW'(sq_shift - sq_trial) : sq_shift[RremW-1:0];
    root_d    = {root_q[RootW-2:0], sq_ge};
  end

  // Next state.
  logic k_last;
  assign k_last = ({1'b0, k_q} == groups - CountW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_ACC:   if (in_acc && in_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_READ;
      S_READ:  state_d = S_MUL;
      S_MUL:   state_d = S_DIFF;
      S_DIFF:  state_d = S_MEAN;
      S_MEAN:  if (cnt_q == 7'(DivW - 1)) state_d = S_VAR;
      S_VAR:   if (cnt_q == 7'(DivW - 1)) state_d = S_ROOT;
      S_ROOT:  if (cnt_q == 7'(RootW - 1)) state_d = S_OUT;
      S_OUT: begin
        if (res_o.ready) state_d = k_last ? S_ACC : S_READ;
      end
      default: state_d = S_ACC;
    endcase
  end

  // Control outputs. Register writes are held off while results are owed,
  // so the shape cannot change under a run that is being emitted.
  always_comb begin
    elem_i.ready = (state_q == S_ACC);
    cfg_i.ready  = (state_q == S_ACC);
    rd_addr      = (state_q == S_ACC) ? in_group : k_q;
    wr_en        = s1_valid_q;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // Read-modify-write of the group entry.
  entry_t old_entry;
  logic signed [2*ElemW-1:0] sq_val;

  always_comb begin
    old_entry = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_entry_q : rd_q;
    sq_val    = s1_val_q * s1_val_q;
    if (s1_first_q) begin
      wr_entry.sum  = SumW'(s1_val_q);
      wr_entry.sq   = SqW'(unsigned'(sq_val));
      wr_entry.maxv = s1_val_q;
      wr_entry.minv = s1_val_q;
    end else begin
      wr_entry.sum  = old_entry.sum + SumW'(s1_val_q);
      wr_entry.sq   = old_entry.sq + SqW'(unsigned'(sq_val));
      wr_entry.maxv = (s1_val_q > old_entry.maxv) ? s1_val_q : old_entry.maxv;
      wr_entry.minv = (s1_val_q < old_entry.minv) ? s1_val_q : old_entry.minv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= wr_entry;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_ACC;
      row_count_q    <= CountW'(1);
      column_count_q <= CountW'(1);
      axis_mode_q    <= AXIS_ROW;
      row_pos_q      <= '0;
      col_pos_q      <= '0;
      s1_valid_q     <= 1'b0;
      fwd_valid_q    <= 1'b0;
      res_valid_q    <= 1'b0;
      k_q            <= '0;
      cnt_q          <= '0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= in_acc;
      fwd_valid_q <= s1_valid_q;
      if (cfg_wr && cfg_i.data.index != 2'd3) begin
        row_pos_q <= '0;
        col_pos_q <= '0;
        case (cfg_i.data.index)
          CFG_ROW_COUNT: row_count_q <= cfg_i.data.value;
          CFG_COLUMN_COUNT: column_count_q <= cfg_i.data.value;
          default: axis_mode_q <= cfg_i.data.value[1:0];
        endcase
      end else if (in_acc) begin
        if (col_wrap) begin
          col_pos_q <= '0;
          row_pos_q <= in_last ? '0 : row_pos_q + GroupW'(1);
        end else begin
          col_pos_q <= col_pos_q + GroupW'(1);
        end
      end
      if (state_q == S_DRAIN) k_q <= '0;
      if (state_q == S_MEAN || state_q == S_VAR) begin
        cnt_q <= (cnt_q == 7'(DivW - 1)) ? '0 : cnt_q + 7'd1;
      end else if (state_q == S_ROOT) begin
        cnt_q <= (cnt_q == 7'(RootW - 1)) ? '0 : cnt_q + 7'd1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == S_ROOT && cnt_q == 7'(RootW - 1)) res_valid_q <= 1'b1;
      if (state_q == S_OUT && res_o.ready) begin
        res_valid_q <= 1'b0;
        k_q         <= k_q + GroupW'(1);
      end
    end
  end

  // Payload registers.
  logic [SumW-1:0] mag;
  assign mag = e_sum_q[SumW-1] ? SumW'(-e_sum_q) : SumW'(e_sum_q);

  always_ff @(posedge clk_i) begin
    s1_val_q    <= elem_i.data.element_value;
    s1_addr_q   <= in_group;
    s1_first_q  <= in_first;
    fwd_addr_q  <= s1_addr_q;
    fwd_entry_q <= wr_entry;
    case (state_q)
      S_MUL: begin
        e_sum_q  <= rd_q.sum;
        e_max_q  <= rd_q.maxv;
        e_min_q  <= rd_q.minv;
        prod_a_q <= n_grp * rd_q.sq;
        nn_q     <= DvsW'(n_grp * n_grp);
      end
      S_DIFF: begin
        prod_b_q  <= (2*NW+30)'(mag * mag);
        div_quo_q <= DivW'({mag, 8'b0});
        div_rem_q <= '0;
      end
      S_MEAN: begin
        if (cnt_q == 7'(DivW - 1)) begin
          mean_q    <= e_sum_q[SumW-1] ? MeanW'(-div_quo_d[MeanW-1:0])
                                       : div_quo_d[MeanW-1:0];
          div_quo_q <= {prod_a_q - prod_b_q, 16'b0};
          div_rem_q <= '0;
        end else begin
          div_quo_q <= div_quo_d;
          div_rem_q <= div_rem_d;
        end
      end
      S_VAR: begin
        div_quo_q <= div_quo_d;
        div_rem_q <= div_rem_d;
        if (cnt_q == 7'(DivW - 1)) begin
          rad_q  <= div_quo_d[RadW-1:0];
          root_q <= '0;
          srem_q <= '0;
        end
      end
      S_ROOT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        root_q <= root_d;
        srem_q <= srem_d;
        if (cnt_q == 7'(RootW - 1)) begin
          res_q.group_index     <= k_q;
          res_q.group_sum       <= e_sum_q;
          res_q.group_mean_q8   <= mean_q;
          res_q.group_maximum   <= e_max_q;
          res_q.group_minimum   <= e_min_q;
          res_q.group_stddev_q8 <= root_d;
          res_q.last_result     <= k_last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/mrcs_checker.sv =====
// Port-level checker for the statistics block, bound to its top level.
module mrcs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic signed [15:0]         res_max_i,
  input logic signed [15:0]         res_min_i,
  input logic                       res_last_i,
  input logic [5:0]                 res_index_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_index_i)
      && $stable(res_max_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !in_ready_i)
    else $error("element taken while results are pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_max_i >= res_min_i)
    else $error("maximum below minimum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_last_i |=> !res_valid_i && in_ready_i)
    else $error("run did not end after final result");

endmodule

bind matrix_row_column_statistics mrcs_checker u_mrcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (elem_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_max_i   (res_o.data.group_maximum),
  .res_min_i   (res_o.data.group_minimum),
  .res_last_i  (res_o.data.last_result),
  .res_index_i (res_o.data.group_index)
);

// ===== dv/mrcs_tb_if.sv =====
`timescale 1ns / 100ps
// The testbench drives the block through the channel interfaces of the RTL interface file.

// ===== dv/matrix_row_column_statistics_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the matrix row, column and whole-matrix statistics block.
module matrix_row_column_statistics_test;
  import mrcs_pkg::*;

  logic clk_i;
  logic rst_ni;

  mrcs_cfg_if  cfg_ch ();
  mrcs_elem_if elem_ch ();
  mrcs_res_if  res_ch ();

  matrix_row_column_statistics dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .elem_i (elem_ch.sink),
    .res_o  (res_ch.source)
  );

  // Predictor state: the shape registers and the per-group accumulators.
  logic [CountW-1:0] shape_rows, shape_cols;
  logic [1:0]        shape_axis;
  longint            grp_sum [64];
  longint unsigned   grp_sq  [64];
  longint            grp_max [64];
  longint            grp_min [64];
  int unsigned       pos_row, pos_col;

  elem_t   pending_elems[$];
  result_t expected_stats[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned result_count;
  int unsigned run_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Exact floor of 256 times the population deviation, done in integers.
  function automatic longint unsigned deviation_q8(longint s, longint unsigned sq,
                                                   longint unsigned n);
    longint unsigned mag, d, nn, q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    d   = n * sq - mag * mag;
    nn  = n * n;
    q   = ((d / nn) << 16) + (((d % nn) << 16) / nn);
    return int_sqrt(q);
  endfunction

  function automatic int unsigned clamp_shape(int unsigned v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Folds one accepted element into the predicted accumulators and, on the
  // last element of the matrix, queues the statistics of every group.
  task automatic predict_element(input elem_t e);
    int unsigned     rows, cols, mode, g, groups, k;
    bit              first;
    longint          v, mean;
    longint unsigned n;
    result_t         r;
    rows = clamp_shape(shape_rows);
    cols = clamp_shape(shape_cols);
    mode = (shape_axis > AXIS_WHOLE) ? AXIS_WHOLE : shape_axis;
    v    = e.element_value;
    if (mode == AXIS_ROW) begin
      g = pos_row; first = (pos_col == 0); groups = rows;
    end else if (mode == AXIS_COLUMN) begin
      g = pos_col; first = (pos_row == 0); groups = cols;
    end else begin
      g = 0; first = (pos_row == 0 && pos_col == 0); groups = 1;
    end
    g = g & 63;
    if (first) begin
      grp_sum[g] = v; grp_sq[g] = v * v; grp_max[g] = v; grp_min[g] = v;
    end else begin
      grp_sum[g] += v;
      grp_sq[g]  += v * v;
      if (v > grp_max[g]) grp_max[g] = v;
      if (v < grp_min[g]) grp_min[g] = v;
    end
    pos_col++;
    if (pos_col < cols) return;
    pos_col = 0;
    pos_row++;
    if (pos_row < rows) return;
    pos_row = 0;
    run_count++;
    n = (mode == AXIS_ROW) ? cols : (mode == AXIS_COLUMN) ? rows : rows * cols;
    for (k = 0; k < groups; k++) begin
      mean              = (grp_sum[k] * 256) / longint'(n);
      r.group_index     = k[GroupW-1:0];
      r.group_sum       = grp_sum[k][SumW-1:0];
      r.group_mean_q8   = mean[MeanW-1:0];
      r.group_maximum   = grp_max[k][ElemW-1:0];
      r.group_minimum   = grp_min[k][ElemW-1:0];
      r.group_stddev_q8 = deviation_q8(grp_sum[k], grp_sq[k], n);
      r.last_result     = (k + 1 == groups);
      expected_stats.push_back(r);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Element driver: presents the queue head, idling at the chosen rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_ch.valid <= 1'b0;
      elem_ch.data  <= '0;
    end else begin
      if (elem_ch.valid && elem_ch.ready) begin
        predict_element(elem_ch.data);
        void'(pending_elems.pop_front());
      end
      if (pending_elems.size() > (elem_ch.valid && elem_ch.ready ? 0 : 0) &&
          !(elem_ch.valid && !elem_ch.ready) &&
          $urandom_range(99) < send_idle_pct) begin
        elem_ch.valid <= 1'b0;
      end else if (pending_elems.size() > 0 && !(elem_ch.valid && !elem_ch.ready)) begin
        elem_ch.valid <= 1'b1;
        elem_ch.data  <= pending_elems[0];
      end else if (pending_elems.size() == 0) begin
        elem_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: random back-pressure, each transaction checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        result_count++;
        if (expected_stats.size() == 0) begin
          $error("unexpected result transaction for group %0d", res_ch.data.group_index);
          error_count++;
        end else begin
          exp_r = expected_stats.pop_front();
          if (res_ch.data.group_index !== exp_r.group_index) begin
            $error("group_index: expected %0d, actual %0d",
                   exp_r.group_index, res_ch.data.group_index);
            error_count++;
          end
          if (res_ch.data.group_sum !== exp_r.group_sum) begin
            $error("group_sum: expected %0d, actual %0d",
                   exp_r.group_sum, res_ch.data.group_sum);
            error_count++;
          end
          if (res_ch.data.group_mean_q8 !== exp_r.group_mean_q8) begin
            $error("group_mean_q8: expected %0d, actual %0d",
                   exp_r.group_mean_q8, res_ch.data.group_mean_q8);
            error_count++;
          end
          if (res_ch.data.group_maximum !== exp_r.group_maximum) begin
            $error("group_maximum: expected %0d, actual %0d",
                   exp_r.group_maximum, res_ch.data.group_maximum);
            error_count++;
          end
          if (res_ch.data.group_minimum !== exp_r.group_minimum) begin
            $error("group_minimum: expected %0d, actual %0d",
                   exp_r.group_minimum, res_ch.data.group_minimum);
            error_count++;
          end
          if (res_ch.data.group_stddev_q8 !== exp_r.group_stddev_q8) begin
            $error("group_stddev_q8: expected %0d, actual %0d",
                   exp_r.group_stddev_q8, res_ch.data.group_stddev_q8);
            error_count++;
          end
          if (res_ch.data.last_result !== exp_r.last_result) begin
            $error("last_result: expected %0d, actual %0d",
                   exp_r.last_result, res_ch.data.last_result);
            error_count++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog. About 220 elements, each at worst ending a run of 64 groups,
  // stay well below this limit even under heavy stalling.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 10000000) begin
      $display("matrix_row_column_statistics_test failed");
      $finish;
    end
  end

  // Waits until the block is idle: queue empty, no results owed, drain done.
  task automatic wait_idle();
    while (pending_elems.size() != 0 || elem_ch.valid || expected_stats.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Register write; the predictor follows the block in aborting the run.
  task automatic write_reg(input cfg_reg_e idx, input logic [CountW-1:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ROW_COUNT:    shape_rows = val;
      CFG_COLUMN_COUNT: shape_cols = val;
      default:          shape_axis = val[1:0];
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  task automatic set_shape(input int unsigned r, input int unsigned c, input axis_e a);
    wait_idle();
    write_reg(CFG_ROW_COUNT, r[CountW-1:0]);
    write_reg(CFG_COLUMN_COUNT, c[CountW-1:0]);
    write_reg(CFG_AXIS_MODE, CountW'(a));
  endtask

  // Queues whole matrices of random elements; some lean on the field extremes.
  task automatic queue_matrices(input int unsigned count);
    int unsigned m, i, total, pick;
    elem_t e;
    total = clamp_shape(shape_rows) * clamp_shape(shape_cols);
    for (m = 0; m < count; m++) begin
      pick = $urandom_range(3);
      for (i = 0; i < total; i++) begin
        case (pick)
          0: e.element_value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          1: e.element_value = ElemW'($urandom_range(200) - 100);
          default: e.element_value = ElemW'($urandom);
        endcase
        pending_elems.push_back(e);
      end
    end
  endtask

  initial begin
    int unsigned ph, r, c, a;
    elem_t e;
    rst_ni         = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    shape_rows     = 1;
    shape_cols     = 1;
    shape_axis     = AXIS_ROW;
    pos_row        = 0;
    pos_col        = 0;
    cycle_count    = 0;
    error_count    = 0;
    result_count   = 0;
    run_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset shape of one element, extremes and a zero.
    e.element_value = 16'sh7fff; pending_elems.push_back(e);
    e.element_value = 16'sh8000; pending_elems.push_back(e);
    e.element_value = 16'sh0000; pending_elems.push_back(e);
    e.element_value = 16'shffff; pending_elems.push_back(e);
    // Out-of-range counts act as 1 and 64; unused axis acts as whole matrix.
    set_shape(0, 0, AXIS_ROW);
    queue_matrices(1);
    set_shape(2, 3, axis_e'(2'd3));
    queue_matrices(1);
    set_shape(3, 2, AXIS_COLUMN);
    queue_matrices(1);
    // A write between partial elements aborts the run in progress.
    set_shape(2, 2, AXIS_ROW);
    e.element_value = 16'sh1234; pending_elems.push_back(e);
    wait_idle();
    write_reg(CFG_AXIS_MODE, CountW'(AXIS_ROW));
    queue_matrices(1);
    // Counts above the maximum clamp to 64: the most groups in both modes.
    set_shape(127, 1, AXIS_ROW);
    queue_matrices(1);
    set_shape(1, 100, AXIS_COLUMN);
    queue_matrices(1);

    // Random shapes through the idling phases; only small matrices of up to 3 by 3.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 18) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 18) : 0;
      repeat (4) begin
        r = $urandom_range(1, 3);
        c = $urandom_range(1, 3);
        a = $urandom_range(0, 2);
        set_shape(r, c, axis_e'(a));
        queue_matrices(1);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    wait_idle();
    $display("Covered %0d matrix runs with %0d group results over row, column and",
             run_count, result_count);
    $display("whole-matrix modes, clamped shapes, aborted runs and random stalls.");
    if (error_count == 0) begin
      $display("matrix_row_column_statistics_test passed");
    end else begin
      $display("matrix_row_column_statistics_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrcs_pkg.sv
rtl/mrcs_if.sv
rtl/matrix_row_column_statistics.sv
rtl/mrcs_checker.sv
dv/mrcs_tb_if.sv
dv/matrix_row_column_statistics_test.sv
